// ----- sv/dtr_pkg.sv -----
// Shared types and constants of the device task registry.
// Holds request and result codes, the task entry layout and the control structs.
// Depends on nothing; every other file of the block uses it.
package dtr_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_DEVICES_DEF = 64;
   localparam int TASK_SLOTS_DEF  = 64;

   // Fixed field widths.
   localparam int REQ_TYPE_W = 3;
   localparam int DEV_ID_W   = 6;
   localparam int TASK_ID_W  = 22;
   localparam int CODE_W     = 3;
   localparam int LIMIT_W    = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Reset value of the device limit register.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Register indexes on the configuration port.
   localparam logic REG_DEVICE_LIMIT = 1'b0;

   // Request types.
   localparam logic [REQ_TYPE_W-1:0] OP_ADD_TASK  = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_DEL_TASK  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_SET_TASK  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_SET_DEV   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_QRY_IDLE  = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] OP_QRY_FAULT = 3'd5;

   // Result codes.
   localparam logic [CODE_W-1:0] RC_OK        = 3'd0;
   localparam logic [CODE_W-1:0] RC_INVALID   = 3'd1;
   localparam logic [CODE_W-1:0] RC_EXISTS    = 3'd2;
   localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd3;
   localparam logic [CODE_W-1:0] RC_NO_TASK   = 3'd4;
   localparam logic [CODE_W-1:0] RC_FULL      = 3'd5;

   // One word of the task table.
   typedef struct packed {
      logic                 valid;
      logic [DEV_ID_W-1:0]  owner;
      logic [TASK_ID_W-1:0] tid;
      logic                 in_use;
   } entry_type;

   // One word of the device table.
   typedef struct packed {
      logic known;
      logic faulty;
   } dev_rec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic scan_rd;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_scan;
   } dp_status_type;

endpackage

// ----- sv/dtr_ctrl.sv -----
// Sequencer of the device task registry: clearing pass, table scan and commit.
// Drives the datapath through dtr_pkg::dp_cmd_type and a shared sweep counter.
// Depends on dtr_pkg.
module dtr_ctrl #(
   parameter int CNT_W   = 7,
   parameter int CLR_LEN = 64,
   parameter int SLOTS   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dtr_pkg::dp_status_type status,
   output dtr_pkg::dp_cmd_type   cmd,
   output logic [CNT_W-1:0]      cnt,
   output logic                  busy
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DEVCHK = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;

   localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(CLR_LEN - 1);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SLOTS - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state, counter and commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (cnt_ff == CLR_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DEVCHK;
            end
         end
         ST_DEVCHK: begin
            cnt_in = '0;
            if (status.need_scan) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (cnt_ff == SCAN_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign cnt  = cnt_ff;
   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- sv/dtr_datapath.sv -----
// Datapath of the device task registry: device table, task table and scan logic.
// Takes commands from dtr_ctrl and registers the result beat.
// Depends on dtr_pkg.
module dtr_datapath #(
   parameter int MAX_DEVICES = dtr_pkg::MAX_DEVICES_DEF,
   parameter int TASK_SLOTS  = dtr_pkg::TASK_SLOTS_DEF,
   parameter int CNT_W       = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dtr_pkg::dp_cmd_type              cmd,
   input  logic [CNT_W-1:0]                 cnt,
   input  logic [dtr_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [dtr_pkg::DEV_ID_W-1:0]     req_device_id,
   input  logic [dtr_pkg::TASK_ID_W-1:0]    req_task_id,
   input  logic                             req_all_tasks,
   input  logic                             req_status_value,
   input  logic [dtr_pkg::LIMIT_W-1:0]      device_limit,
   output dtr_pkg::dp_status_type           status,
   output logic                             rsp_strobe,
   output logic [dtr_pkg::CODE_W-1:0]       rsp_result_code,
   output logic                             rsp_idle,
   output logic                             rsp_fault
);

   localparam int DEV_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int EXT_W  = 9;

   // Tables.
   dtr_pkg::entry_type   ent_mem [TASK_SLOTS];
   dtr_pkg::dev_rec_type dev_mem [MAX_DEVICES];

   // Latched request.
   logic [dtr_pkg::REQ_TYPE_W-1:0] op_ff;
   logic [dtr_pkg::DEV_ID_W-1:0]   dev_ff;
   logic [dtr_pkg::TASK_ID_W-1:0]  tid_ff;
   logic                           all_ff;
   logic                           sv_ff;
   dtr_pkg::dev_rec_type           dev_rd_ff;

   // Scan pipeline and accumulated search results.
   dtr_pkg::entry_type ent_rd_ff;
   logic               rd_vld_ff;
   logic [SLOT_W-1:0]  rd_idx_ff;
   logic               hit_found_ff, free_found_ff;
   logic [SLOT_W-1:0]  hit_idx_ff, free_idx_ff;
   logic               any_busy_ff, other_busy_ff, any_owned_ff;

   // Result registers.
   logic                        strobe_ff;
   logic [dtr_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                        idle_ff, idle_in;
   logic                        fault_ff, fault_in;

   logic [EXT_W-1:0]   req_dev_ext, dev_ext;
   logic [DEV_W-1:0]   req_dev_idx, dev_idx;
   logic               valid_req, known;
   logic               rd_own, rd_hit, rd_free;
   logic               ent_we, dev_we;
   logic [SLOT_W-1:0]  ent_waddr;
   logic [DEV_W-1:0]   dev_waddr;
   dtr_pkg::entry_type   ent_wdata;
   dtr_pkg::dev_rec_type dev_wdata;

   // Device indexes and request validity.
   assign req_dev_ext = EXT_W'(req_device_id);
   assign req_dev_idx = req_dev_ext[DEV_W-1:0];
   assign dev_ext     = EXT_W'(dev_ff);
   assign dev_idx     = dev_ext[DEV_W-1:0];
   assign known       = dev_rd_ff.known;
   assign valid_req   = (op_ff <= dtr_pkg::OP_QRY_FAULT)
                      && (dtr_pkg::LIMIT_W'(dev_ff) < device_limit)
                      && (dev_ext < EXT_W'(MAX_DEVICES));

   // Scan is needed when the answer depends on the task table.
   assign status.need_scan = valid_req
      && ((op_ff == dtr_pkg::OP_ADD_TASK) || (op_ff == dtr_pkg::OP_QRY_IDLE)
          || (((op_ff == dtr_pkg::OP_DEL_TASK) || (op_ff == dtr_pkg::OP_SET_TASK)) && known));

   // Classification of the entry returned by the scan read.
   assign rd_own  = rd_vld_ff && ent_rd_ff.valid && (ent_rd_ff.owner == dev_ff);
   assign rd_hit  = rd_own && (ent_rd_ff.tid == tid_ff);
   assign rd_free = rd_vld_ff && !ent_rd_ff.valid;

   // Request latch and device table read.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_type;
         dev_ff    <= req_device_id;
         tid_ff    <= req_task_id;
         all_ff    <= req_all_tasks;
         sv_ff     <= req_status_value;
         dev_rd_ff <= dev_mem[req_dev_idx];
      end
      if (dev_we) begin
         dev_mem[dev_waddr] <= dev_wdata;
      end
   end

   // Scan read and task table write.
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         ent_rd_ff <= ent_mem[cnt[SLOT_W-1:0]];
         rd_idx_ff <= cnt[SLOT_W-1:0];
      end
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
      end
   end

   // Search accumulators: first match, lowest free entry, in-use summaries.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         hit_idx_ff    <= '0;
         free_idx_ff   <= '0;
         any_busy_ff   <= 1'b0;
         other_busy_ff <= 1'b0;
         any_owned_ff  <= 1'b0;
      end else begin
         if (rd_hit && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= rd_idx_ff;
         end
         if (rd_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
         if (rd_own) begin
            any_owned_ff <= 1'b1;
         end
         if (rd_own && ent_rd_ff.in_use) begin
            any_busy_ff <= 1'b1;
         end
         if (rd_own && ent_rd_ff.in_use && !rd_hit) begin
            other_busy_ff <= 1'b1;
         end
      end
   end

   // Task table write port: clearing pass, bulk status write-back, commit.
   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = rd_idx_ff;
      ent_wdata = ent_rd_ff;
      if (cmd.clear) begin
         ent_we    = (cnt < CNT_W'(TASK_SLOTS));
         ent_waddr = cnt[SLOT_W-1:0];
         ent_wdata = '0;
      end else if (rd_own && (op_ff == dtr_pkg::OP_SET_TASK) && all_ff) begin
         ent_we           = 1'b1;
         ent_waddr        = rd_idx_ff;
         ent_wdata        = ent_rd_ff;
         ent_wdata.in_use = sv_ff;
      end else if (cmd.commit && valid_req) begin
         case (op_ff)
            dtr_pkg::OP_ADD_TASK: begin
               ent_we           = !hit_found_ff && free_found_ff;
               ent_waddr        = free_idx_ff;
               ent_wdata.valid  = 1'b1;
               ent_wdata.owner  = dev_ff;
               ent_wdata.tid    = tid_ff;
               ent_wdata.in_use = 1'b1;
            end
            dtr_pkg::OP_DEL_TASK: begin
               ent_we    = known && hit_found_ff;
               ent_waddr = hit_idx_ff;
               ent_wdata = '0;
            end
            dtr_pkg::OP_SET_TASK: begin
               ent_we           = known && !all_ff && hit_found_ff;
               ent_waddr        = hit_idx_ff;
               ent_wdata.valid  = 1'b1;
               ent_wdata.owner  = dev_ff;
               ent_wdata.tid    = tid_ff;
               ent_wdata.in_use = sv_ff;
            end
            default: begin
               ent_we = 1'b0;
            end
         endcase
      end
   end

   // Device table write port: clearing pass, record creation, fault set.
   always_comb begin
      dev_we    = 1'b0;
      dev_waddr = dev_idx;
      dev_wdata = '0;
      if (cmd.clear) begin
         dev_we    = (cnt < CNT_W'(MAX_DEVICES));
         dev_waddr = cnt[DEV_W-1:0];
      end else if (cmd.commit && valid_req) begin
         if (op_ff == dtr_pkg::OP_ADD_TASK) begin
            dev_we           = !known;
            dev_wdata.known  = 1'b1;
            dev_wdata.faulty = 1'b0;
         end else if (op_ff == dtr_pkg::OP_SET_DEV) begin
            dev_we           = 1'b1;
            dev_wdata.known  = 1'b1;
            dev_wdata.faulty = sv_ff;
         end
      end
   end

   // Result of the request.
   always_comb begin
      code_in  = dtr_pkg::RC_OK;
      idle_in  = 1'b0;
      fault_in = 1'b0;
      if (!valid_req) begin
         code_in = dtr_pkg::RC_INVALID;
      end else begin
         case (op_ff)
            dtr_pkg::OP_ADD_TASK: begin
               if (hit_found_ff) begin
                  code_in = dtr_pkg::RC_EXISTS;
               end else if (!free_found_ff) begin
                  code_in = dtr_pkg::RC_FULL;
               end
            end
            dtr_pkg::OP_DEL_TASK: begin
               if (!known) begin
                  code_in = dtr_pkg::RC_NOT_FOUND;
               end else if (!hit_found_ff) begin
                  code_in = dtr_pkg::RC_NO_TASK;
               end else begin
                  idle_in = !other_busy_ff;
               end
            end
            dtr_pkg::OP_SET_TASK: begin
               if (!known) begin
                  code_in = dtr_pkg::RC_NOT_FOUND;
               end else if (all_ff) begin
                  idle_in = !(sv_ff && any_owned_ff);
               end else if (!hit_found_ff) begin
                  code_in = dtr_pkg::RC_NOT_FOUND;
               end else begin
                  idle_in = !other_busy_ff && !sv_ff;
               end
            end
            dtr_pkg::OP_SET_DEV: begin
               code_in = dtr_pkg::RC_OK;
            end
            dtr_pkg::OP_QRY_IDLE: begin
               idle_in = !known || !any_busy_ff;
            end
            dtr_pkg::OP_QRY_FAULT: begin
               fault_in = known && dev_rd_ff.faulty;
            end
            default: begin
               code_in = dtr_pkg::RC_INVALID;
            end
         endcase
      end
   end

   // Result beat registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         code_ff  <= code_in;
         idle_ff  <= idle_in;
         fault_ff <= fault_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_code = code_ff;
   assign rsp_idle        = idle_ff;
   assign rsp_fault       = fault_ff;

endmodule

// ----- sv/device_task_registry_unit.sv -----
// Top level of the device task registry: configuration register and block wiring.
// Instantiates dtr_ctrl and dtr_datapath; depends on dtr_pkg.
//
//   Channel   Handshake                       Payload
//   request   start in, busy out              req_type, req_device_id, req_task_id,
//                                             req_all_tasks, req_status_value
//   result    rsp_strobe out, one cycle       rsp_result_code, rsp_idle, rsp_fault
//   config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata (device_limit at 0)
//
// A request beat is taken when start is high and busy is low.
// Add, idle query, and delete or task status for a known device scan the task table
// one entry per cycle through its single read port, and busy stays high until the
// commit that follows the scan. All other requests, and requests with an invalid id,
// commit without a scan. After reset a clearing pass over max(TASK_SLOTS, MAX_DEVICES) entries
// (64 by default) keeps busy high. The result beat shows for one cycle and cannot be stalled.
module device_task_registry_unit #(
   parameter int MAX_DEVICES = dtr_pkg::MAX_DEVICES_DEF,
   parameter int TASK_SLOTS  = dtr_pkg::TASK_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dtr_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [dtr_pkg::DEV_ID_W-1:0]      req_device_id,
   input  logic [dtr_pkg::TASK_ID_W-1:0]     req_task_id,
   input  logic                              req_all_tasks,
   input  logic                              req_status_value,
   output logic                              rsp_strobe,
   output logic [dtr_pkg::CODE_W-1:0]        rsp_result_code,
   output logic                              rsp_idle,
   output logic                              rsp_fault,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dtr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [dtr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [dtr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int CLR_LEN = (TASK_SLOTS > MAX_DEVICES) ? TASK_SLOTS : MAX_DEVICES;
   localparam int CNT_W   = $clog2(CLR_LEN + 1);

   logic [dtr_pkg::LIMIT_W-1:0] limit_ff;
   logic                        csr_wr;
   logic                        reg_sel;
   dtr_pkg::dp_cmd_type         cmd;
   dtr_pkg::dp_status_type      status;
   logic [CNT_W-1:0]            cnt;

   // Configuration register.
   assign pready  = 1'b1;
   assign reg_sel = paddr[dtr_pkg::CSR_ADDR_W-1];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dtr_pkg::LIMIT_RESET;
      end else if (csr_wr && (reg_sel == dtr_pkg::REG_DEVICE_LIMIT)) begin
         limit_ff <= pwdata[dtr_pkg::LIMIT_W-1:0];
      end
   end

   assign prdata = (reg_sel == dtr_pkg::REG_DEVICE_LIMIT)
                 ? dtr_pkg::CSR_DATA_W'(limit_ff) : '0;

   dtr_ctrl #(
      .CNT_W   (CNT_W),
      .CLR_LEN (CLR_LEN),
      .SLOTS   (TASK_SLOTS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .cnt    (cnt),
      .busy   (busy)
   );

   dtr_datapath #(
      .MAX_DEVICES (MAX_DEVICES),
      .TASK_SLOTS  (TASK_SLOTS),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cnt              (cnt),
      .req_type         (req_type),
      .req_device_id    (req_device_id),
      .req_task_id      (req_task_id),
      .req_all_tasks    (req_all_tasks),
      .req_status_value (req_status_value),
      .device_limit     (limit_ff),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_code  (rsp_result_code),
      .rsp_idle         (rsp_idle),
      .rsp_fault        (rsp_fault)
   );

endmodule

// ----- sv/dtr_checker.sv -----
// Port-level checks of the device task registry and their binding to the top level.
// Depends on dtr_pkg and device_task_registry_unit.
module dtr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [dtr_pkg::CODE_W-1:0]  rsp_result_code,
   input logic                        rsp_idle,
   input logic                        rsp_fault
);

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request beat accepted but busy did not rise");

   // Result beats never come back to back.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in a row");

   // A result beat is shown while the block is ready for the next request.
   a_beat_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat shown while busy");

   // Result codes stay within the defined set.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_result_code <= dtr_pkg::RC_FULL))
      else $error("undefined result code");

   // A failed request reports neither idle nor fault.
   a_fail_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_result_code != dtr_pkg::RC_OK) |-> !rsp_idle && !rsp_fault)
      else $error("flags set on a failed request");

endmodule

bind device_task_registry_unit dtr_checker u_dtr_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_result_code (rsp_result_code),
   .rsp_idle        (rsp_idle),
   .rsp_fault       (rsp_fault)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the device task registry top level.
// Drives request beats from a queue, predicts each result and checks every result beat.
// Depends on dtr_pkg and device_task_registry_unit.
`timescale 1ns / 100ps

module tb_top;

   localparam int SLOTS          = dtr_pkg::TASK_SLOTS_DEF;
   localparam int DEVICES        = dtr_pkg::MAX_DEVICES_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TID_MAX        = (1 << dtr_pkg::TASK_ID_W) - 1;

   // Request types outside the defined set.
   localparam logic [dtr_pkg::REQ_TYPE_W-1:0] OP_RSVD_LO = 3'd6;
   localparam logic [dtr_pkg::REQ_TYPE_W-1:0] OP_RSVD_HI = 3'd7;

   // One request beat as the sender holds it.
   typedef struct {
      logic [dtr_pkg::REQ_TYPE_W-1:0] op;
      logic [dtr_pkg::DEV_ID_W-1:0]   dev;
      logic [dtr_pkg::TASK_ID_W-1:0]  tid;
      logic                           all_tasks;
      logic                           status;
      bit                             drain;   // wait for all outstanding results first
   } request_type;

   // One result beat as predicted.
   typedef struct {
      logic [dtr_pkg::CODE_W-1:0] code;
      logic                       idle;
      logic                       fault;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [dtr_pkg::REQ_TYPE_W-1:0] req_type = '0;
   logic [dtr_pkg::DEV_ID_W-1:0]   req_device_id = '0;
   logic [dtr_pkg::TASK_ID_W-1:0]  req_task_id = '0;
   logic                           req_all_tasks = 1'b0;
   logic                           req_status_value = 1'b0;
   logic                           rsp_strobe;
   logic [dtr_pkg::CODE_W-1:0]     rsp_result_code;
   logic                           rsp_idle;
   logic                           rsp_fault;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [dtr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [dtr_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [dtr_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   device_task_registry_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_device_id(req_device_id), .req_task_id(req_task_id),
      .req_all_tasks(req_all_tasks), .req_status_value(req_status_value),
      .rsp_strobe(rsp_strobe), .rsp_result_code(rsp_result_code),
      .rsp_idle(rsp_idle), .rsp_fault(rsp_fault),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the registry state and the device limit.
   logic [dtr_pkg::LIMIT_W-1:0]   shadow_limit;
   logic                          dev_known  [DEVICES];
   logic                          dev_faulty [DEVICES];
   logic                          slot_valid [SLOTS];
   logic [dtr_pkg::DEV_ID_W-1:0]  slot_owner [SLOTS];
   logic [dtr_pkg::TASK_ID_W-1:0] slot_task  [SLOTS];
   logic                          slot_in_use[SLOTS];

   request_type pending_reqs[$];
   outcome_type expected_outcomes[$];
   request_type cur_req;
   int          burst_left = 1;
   int          gap_left = 0;
   int          errors = 0;
   int          stall_cycles = 0;

   // Registry lookups on the shadow state.
   function automatic int find_slot(input logic [dtr_pkg::DEV_ID_W-1:0] dev,
                                    input logic [dtr_pkg::TASK_ID_W-1:0] tid);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_owner[i] == dev && slot_task[i] == tid) return i;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!slot_valid[i]) return i;
      return -1;
   endfunction

   function automatic logic device_idle(input logic [dtr_pkg::DEV_ID_W-1:0] dev);
      if (!dev_known[dev]) return 1'b1;
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_owner[i] == dev && slot_in_use[i]) return 1'b0;
      return 1'b1;
   endfunction

   // Applies one request to the shadow registry and returns the result it gives.
   function automatic outcome_type registry_apply(input request_type r);
      outcome_type o;
      int slot;
      o.code = dtr_pkg::RC_OK;
      o.idle = 1'b0;
      o.fault = 1'b0;
      if (r.op > dtr_pkg::OP_QRY_FAULT || {1'b0, r.dev} >= shadow_limit) begin
         o.code = dtr_pkg::RC_INVALID;
      end else begin
         case (r.op)
            dtr_pkg::OP_ADD_TASK: begin
               if (!dev_known[r.dev]) begin
                  dev_known[r.dev] = 1'b1;
                  dev_faulty[r.dev] = 1'b0;
               end
               if (find_slot(r.dev, r.tid) >= 0) begin
                  o.code = dtr_pkg::RC_EXISTS;
               end else begin
                  slot = free_slot();
                  if (slot < 0) begin
                     o.code = dtr_pkg::RC_FULL;
                  end else begin
                     slot_valid[slot] = 1'b1;
                     slot_owner[slot] = r.dev;
                     slot_task[slot] = r.tid;
                     slot_in_use[slot] = 1'b1;
                  end
               end
            end
            dtr_pkg::OP_DEL_TASK: begin
               if (!dev_known[r.dev]) begin
                  o.code = dtr_pkg::RC_NOT_FOUND;
               end else begin
                  slot = find_slot(r.dev, r.tid);
                  if (slot < 0) begin
                     o.code = dtr_pkg::RC_NO_TASK;
                  end else begin
                     slot_valid[slot] = 1'b0;
                     o.idle = device_idle(r.dev);
                  end
               end
            end
            dtr_pkg::OP_SET_TASK: begin
               if (!dev_known[r.dev]) begin
                  o.code = dtr_pkg::RC_NOT_FOUND;
               end else if (r.all_tasks) begin
                  for (int i = 0; i < SLOTS; i++)
                     if (slot_valid[i] && slot_owner[i] == r.dev) slot_in_use[i] = r.status;
                  o.idle = device_idle(r.dev);
               end else begin
                  slot = find_slot(r.dev, r.tid);
                  if (slot < 0) begin
                     o.code = dtr_pkg::RC_NOT_FOUND;
                  end else begin
                     slot_in_use[slot] = r.status;
                     o.idle = device_idle(r.dev);
                  end
               end
            end
            dtr_pkg::OP_SET_DEV: begin
               if (!dev_known[r.dev]) dev_known[r.dev] = 1'b1;
               dev_faulty[r.dev] = r.status;
            end
            dtr_pkg::OP_QRY_IDLE: begin
               o.idle = device_idle(r.dev);
            end
            default: begin
               o.fault = dev_known[r.dev] && dev_faulty[r.dev];
            end
         endcase
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Queues one request for the driver.
   task automatic queue_req(input logic [dtr_pkg::REQ_TYPE_W-1:0] op, input int dev,
                            input int tid, input int all_tasks, input int status);
      request_type r;
      r.op = op;
      r.dev = dtr_pkg::DEV_ID_W'(dev);
      r.tid = dtr_pkg::TASK_ID_W'(tid);
      r.all_tasks = (all_tasks != 0);
      r.status = (status != 0);
      r.drain = 1'b0;
      pending_reqs.push_back(r);
   endtask

   // Random requests: mostly a few devices and a small pool of task ids, so that
   // lookups hit, plus full-range ids and the odd unknown request type.
   task automatic queue_random(input int count);
      request_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) r.op = dtr_pkg::OP_ADD_TASK;
         else if (pick < 50) r.op = dtr_pkg::OP_DEL_TASK;
         else if (pick < 68) r.op = dtr_pkg::OP_SET_TASK;
         else if (pick < 78) r.op = dtr_pkg::OP_SET_DEV;
         else if (pick < 88) r.op = dtr_pkg::OP_QRY_IDLE;
         else if (pick < 97) r.op = dtr_pkg::OP_QRY_FAULT;
         else r.op = ($urandom_range(0, 1) == 0) ? OP_RSVD_LO : OP_RSVD_HI;
         r.dev = dtr_pkg::DEV_ID_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                                : $urandom_range(0, 63));
         pick = $urandom_range(0, 9);
         if (pick < 7) r.tid = dtr_pkg::TASK_ID_W'($urandom_range(0, 5));
         else if (pick < 9) r.tid = dtr_pkg::TASK_ID_W'($urandom);
         else r.tid = '1;
         r.all_tasks = ($urandom_range(0, 3) == 0);
         r.status = ($urandom_range(0, 1) == 1);
         r.drain = ($urandom_range(0, 39) == 0) || (n == count / 2);
         pending_reqs.push_back(r);
      end
   endtask

   // Waits until every queued request has been taken and answered.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || expected_outcomes.size() != 0 || busy);
   endtask

   // Writes the device limit through a setup and an access phase.
   task automatic write_limit(input logic [dtr_pkg::LIMIT_W-1:0] value);
      logic [dtr_pkg::CSR_DATA_W-1:0] junk;
      junk = $urandom;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {{(dtr_pkg::CSR_ADDR_W-1){1'b0}}, dtr_pkg::REG_DEVICE_LIMIT};
      pwdata <= {junk[dtr_pkg::CSR_DATA_W-1:dtr_pkg::LIMIT_W], value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow_limit = value;
      @(negedge clock);
   endtask

   // Driver: presents queued beats in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_outcomes.push_back(registry_apply(cur_req));
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
            end
         end
         if (start && busy) begin
            // Hold the beat until the block takes it.
         end else if (gap_left == 0 && pending_reqs.size() != 0 &&
                      (!pending_reqs[0].drain || expected_outcomes.size() == 0)) begin
            cur_req = pending_reqs.pop_front();
            start <= 1'b1;
            req_type <= cur_req.op;
            req_device_id <= cur_req.dev;
            req_task_id <= cur_req.tid;
            req_all_tasks <= cur_req.all_tasks;
            req_status_value <= cur_req.status;
         end else begin
            if (gap_left > 0) gap_left--;
            start <= 1'b0;
            req_type <= dtr_pkg::REQ_TYPE_W'($urandom);
            req_device_id <= dtr_pkg::DEV_ID_W'($urandom);
            req_task_id <= dtr_pkg::TASK_ID_W'($urandom);
            req_all_tasks <= 1'($urandom);
            req_status_value <= 1'($urandom);
         end
      end
   end

   // Monitor: checks each result beat against the oldest prediction.
   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat, code", int'(rsp_result_code), -1);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_result_code !== want.code)
               report_mismatch("result_code", int'(rsp_result_code), int'(want.code));
            if (rsp_idle !== want.idle)
               report_mismatch("idle", int'(rsp_idle), int'(want.idle));
            if (rsp_fault !== want.fault)
               report_mismatch("fault", int'(rsp_fault), int'(want.fault));
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus phases, with limit changes between them while the block is idle.
   initial begin
      shadow_limit = dtr_pkg::LIMIT_RESET;
      for (int i = 0; i < DEVICES; i++) begin
         dev_known[i] = 1'b0;
         dev_faulty[i] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_owner[i] = '0;
         slot_task[i] = '0;
         slot_in_use[i] = 1'b0;
      end

      // Directed: unknown devices, duplicates, missing tasks, all-task updates,
      // fault flags and unknown request types.
      queue_req(dtr_pkg::OP_QRY_IDLE, 0, 0, 0, 0);
      queue_req(dtr_pkg::OP_QRY_FAULT, 63, 0, 0, 0);
      queue_req(dtr_pkg::OP_DEL_TASK, 5, 1, 0, 0);
      queue_req(dtr_pkg::OP_SET_TASK, 5, 1, 0, 1);
      queue_req(dtr_pkg::OP_ADD_TASK, 5, 0, 0, 0);
      queue_req(dtr_pkg::OP_ADD_TASK, 5, 0, 0, 1);
      queue_req(dtr_pkg::OP_ADD_TASK, 63, TID_MAX, 1, 1);
      queue_req(dtr_pkg::OP_SET_TASK, 5, 7, 0, 0);
      queue_req(dtr_pkg::OP_SET_TASK, 5, 0, 0, 0);
      queue_req(dtr_pkg::OP_QRY_IDLE, 5, 0, 0, 0);
      queue_req(dtr_pkg::OP_SET_TASK, 5, TID_MAX, 1, 1);
      queue_req(dtr_pkg::OP_QRY_IDLE, 5, 0, 0, 0);
      queue_req(dtr_pkg::OP_DEL_TASK, 5, 9, 0, 0);
      queue_req(dtr_pkg::OP_DEL_TASK, 5, 0, 0, 0);
      queue_req(dtr_pkg::OP_SET_TASK, 5, 0, 1, 1);
      queue_req(dtr_pkg::OP_SET_DEV, 10, 0, 0, 1);
      queue_req(dtr_pkg::OP_QRY_FAULT, 10, 0, 0, 0);
      queue_req(dtr_pkg::OP_SET_DEV, 10, 0, 0, 0);
      queue_req(dtr_pkg::OP_QRY_FAULT, 10, 0, 0, 0);
      queue_req(OP_RSVD_LO, 1, 0, 0, 0);
      queue_req(OP_RSVD_HI, 63, TID_MAX, 1, 1);
      queue_req(dtr_pkg::OP_DEL_TASK, 63, TID_MAX, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // Smallest useful limit: only device 0 is valid.
      write_limit(7'd1);
      queue_req(dtr_pkg::OP_QRY_IDLE, 1, 0, 0, 0);
      queue_req(dtr_pkg::OP_ADD_TASK, 0, 3, 0, 0);
      queue_req(dtr_pkg::OP_SET_DEV, 63, 0, 0, 1);
      queue_random(30);
      wait_drained();

      // Zero limit: every id is invalid.
      write_limit(7'd0);
      queue_req(dtr_pkg::OP_ADD_TASK, 0, 0, 0, 0);
      queue_random(15);
      wait_drained();

      // Largest limit: fill the table, then hit it full with a new device.
      write_limit(7'd127);
      for (int k = 0; k < SLOTS + 6; k++)
         queue_req(dtr_pkg::OP_ADD_TASK, k % 12, 100 + k, 0, 0);
      queue_req(dtr_pkg::OP_ADD_TASK, 40, 1, 0, 0);
      queue_req(dtr_pkg::OP_QRY_IDLE, 40, 0, 0, 0);
      queue_req(dtr_pkg::OP_QRY_FAULT, 40, 0, 0, 0);
      queue_random(200);
      wait_drained();

      // Reset value again: empty the filled entries, then random traffic.
      write_limit(dtr_pkg::LIMIT_RESET);
      for (int k = 0; k < SLOTS + 6; k++)
         queue_req(dtr_pkg::OP_DEL_TASK, k % 12, 100 + k, 0, 0);
      queue_random(150);
      wait_drained();

      // A random limit in between.
      write_limit(dtr_pkg::LIMIT_W'($urandom_range(2, 63)));
      queue_random(100);
      wait_drained();

      repeat (SLOTS + 8) @(negedge clock);
      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
